@@ src/ktst_pkg.sv @@
// Shared constants for the keyed timer slot table.
package ktst_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 24;
  localparam int unsigned KEY_BITS_DEF   = 8;
  localparam int unsigned KEY_W          = 8;
  localparam int unsigned TIME_W         = 32;

  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;
  localparam logic [1:0] FUNC_TICK   = 2'd3;

  localparam logic [2:0] KIND_STARTED = 3'd0;
  localparam logic [2:0] KIND_FULL    = 3'd1;
  localparam logic [2:0] KIND_CANCEL  = 3'd2;
  localparam logic [2:0] KIND_QUERY   = 3'd3;
  localparam logic [2:0] KIND_EXPIRED = 3'd4;

endpackage

@@ src/ktst_if.sv @@
// Request and result channel interfaces of the keyed timer slot table.
interface ktst_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    func;
  logic [ktst_pkg::KEY_W-1:0]    key;
  logic [ktst_pkg::TIME_W-1:0]   duration_ms;
  logic [ktst_pkg::TIME_W-1:0]   tag;
  modport source (output valid, func, key, duration_ms, tag, input ready);
  modport sink (input valid, func, key, duration_ms, tag, output ready);
endinterface

interface ktst_out_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    kind;
  logic                          found;
  logic [ktst_pkg::KEY_W-1:0]    out_key;
  logic [ktst_pkg::TIME_W-1:0]   out_tag;
  logic                          last;
  modport source (output valid, kind, found, out_key, out_tag, last, input ready);
  modport sink (input valid, kind, found, out_key, out_tag, last, output ready);
endinterface

@@ src/ktst_cell.sv @@
// One timer slot of the rotating slot chain.
module ktst_cell #(
  parameter int unsigned KEY_BITS = ktst_pkg::KEY_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        shift_i,
  input  logic                        valid_i,
  input  logic [KEY_BITS-1:0]         key_i,
  input  logic [ktst_pkg::TIME_W-1:0] start_i,
  input  logic [ktst_pkg::TIME_W-1:0] dur_i,
  input  logic [ktst_pkg::TIME_W-1:0] tag_i,
  output logic                        valid_o,
  output logic [KEY_BITS-1:0]         key_o,
  output logic [ktst_pkg::TIME_W-1:0] start_o,
  output logic [ktst_pkg::TIME_W-1:0] dur_o,
  output logic [ktst_pkg::TIME_W-1:0] tag_o
);

  logic                        valid_q;
  logic [KEY_BITS-1:0]         key_q;
  logic [ktst_pkg::TIME_W-1:0] start_q, dur_q, tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      key_q   <= key_i;
      start_q <= start_i;
      dur_q   <= dur_i;
      tag_q   <= tag_i;
    end
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign start_o = start_q;
  assign dur_o   = dur_q;
  assign tag_o   = tag_q;

endmodule

@@ src/keyed_timer_slot_table_unit.sv @@
// Top level of the keyed timer slot table: slot chain and scan controller.
//
// Requests arrive on in_i (func, key, duration_ms, tag) and results leave on
// out_o (kind, found, out_key, out_tag, last). Start, cancel and query each
// give one result with last set; a millisecond tick gives one expired result
// per timer that ran out, in slot order, the final one with last set, or
// none at all.
// The slots sit in a ring of cells that rotates by one position per cycle;
// the controller looks at the head cell, updates it and feeds it back into
// the tail, so one request passes every one of the SLOT_COUNT slots through
// the head once and then finishes with a closing step that emits its last result, if any.
// One request is in work at a time; in_i.ready is high while idle.
// Results are held in an output register. If the receiver stalls, the ring
// stops rotating whenever a result has to be emitted and the register is
// still full, and resumes when the result is taken.
// Reset clears all slot valid marks and the millisecond counter to zero.
module keyed_timer_slot_table_unit #(
  parameter int unsigned SLOT_COUNT = ktst_pkg::SLOT_COUNT_DEF,
  parameter int unsigned KEY_BITS   = ktst_pkg::KEY_BITS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  ktst_in_if.sink   in_i,
  ktst_out_if.source out_o
);

  localparam int unsigned CW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned WK = (KEY_BITS > ktst_pkg::KEY_W) ? KEY_BITS : ktst_pkg::KEY_W;
  localparam int unsigned TW = ktst_pkg::TIME_W;

  // Ring of cells; index 0 is the head.
  logic                c_valid [SLOT_COUNT];
  logic [KEY_BITS-1:0] c_key   [SLOT_COUNT];
  logic [TW-1:0]       c_start [SLOT_COUNT];
  logic [TW-1:0]       c_dur   [SLOT_COUNT];
  logic [TW-1:0]       c_tag   [SLOT_COUNT];

  logic                n_valid [SLOT_COUNT];
  logic [KEY_BITS-1:0] n_key   [SLOT_COUNT];
  logic [TW-1:0]       n_start [SLOT_COUNT];
  logic [TW-1:0]       n_dur   [SLOT_COUNT];
  logic [TW-1:0]       n_tag   [SLOT_COUNT];

  logic                m_valid;
  logic [KEY_BITS-1:0] m_key;
  logic [TW-1:0]       m_start, m_dur, m_tag;
  logic                shift;

  for (genvar j = 0; j < SLOT_COUNT; j++) begin : g_cell
    if (j == SLOT_COUNT - 1) begin : g_tail
      assign n_valid[j] = m_valid;
      assign n_key[j]   = m_key;
      assign n_start[j] = m_start;
      assign n_dur[j]   = m_dur;
      assign n_tag[j]   = m_tag;
    end else begin : g_mid
      assign n_valid[j] = c_valid[j+1];
      assign n_key[j]   = c_key[j+1];
      assign n_start[j] = c_start[j+1];
      assign n_dur[j]   = c_dur[j+1];
      assign n_tag[j]   = c_tag[j+1];
    end
    ktst_cell #(.KEY_BITS(KEY_BITS)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .valid_i (n_valid[j]),
      .key_i   (n_key[j]),
      .start_i (n_start[j]),
      .dur_i   (n_dur[j]),
      .tag_i   (n_tag[j]),
      .valid_o (c_valid[j]),
      .key_o   (c_key[j]),
      .start_o (c_start[j]),
      .dur_o   (c_dur[j]),
      .tag_o   (c_tag[j])
    );
  end

  // Controller state.
  logic                busy_q, busy_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [1:0]          func_q;
  logic [KEY_BITS-1:0] key_q;
  logic [TW-1:0]       dur_q, tag_q;
  logic                hit_q, hit_d;
  logic                pend_q, pend_d;
  logic [KEY_BITS-1:0] pkey_q, pkey_d;
  logic [TW-1:0]       ptag_q, ptag_d;
  logic [TW-1:0]       now_q;

  logic                ov_q, ov_d;
  logic [2:0]          okind_q, okind_d;
  logic                ofound_q, ofound_d;
  logic [KEY_BITS-1:0] okey_q, okey_d;
  logic [TW-1:0]       otag_q, otag_d;
  logic                olast_q, olast_d;

  logic                accept, can_load, key_match;
  logic [WK-1:0]       in_key_w, out_key_w;
  logic [TW-1:0]       elapsed;

  assign accept   = in_i.valid && in_i.ready;
  assign can_load = !ov_q || out_o.ready;
  assign in_key_w = WK'(in_i.key);
  assign key_match = c_key[0] == key_q;
  assign elapsed   = now_q - c_start[0];

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    hit_d   = hit_q;
    pend_d  = pend_q;
    pkey_d  = pkey_q;
    ptag_d  = ptag_q;
    ov_d    = ov_q && !out_o.ready;
    okind_d = okind_q;
    ofound_d = ofound_q;
    okey_d  = okey_q;
    otag_d  = otag_q;
    olast_d = olast_q;
    m_valid = c_valid[0];
    m_key   = c_key[0];
    m_start = c_start[0];
    m_dur   = c_dur[0];
    m_tag   = c_tag[0];
    shift   = 1'b0;
    if (busy_q && (cnt_q < CW'(SLOT_COUNT))) begin
      shift = 1'b1;
      unique case (func_q)
        ktst_pkg::FUNC_START: begin
          if (!hit_q && (!c_valid[0] || key_match)) begin
            m_valid = 1'b1;
            m_key   = key_q;
            m_start = now_q;
            m_dur   = dur_q;
            m_tag   = tag_q;
            hit_d   = 1'b1;
          end else if (hit_q && c_valid[0] && key_match) begin
            m_valid = 1'b0;
          end
        end
        ktst_pkg::FUNC_CANCEL: begin
          if (!hit_q && c_valid[0] && key_match) begin
            m_valid = 1'b0;
            hit_d   = 1'b1;
          end
        end
        ktst_pkg::FUNC_QUERY: begin
          if (c_valid[0] && key_match) hit_d = 1'b1;
        end
        default: begin
          if (c_valid[0] && (elapsed >= c_dur[0])) begin
            // A second expiry pushes the held one out, which needs the register.
            if (pend_q && !can_load) begin
              shift = 1'b0;
            end else begin
              m_valid = 1'b0;
              if (pend_q) begin
                ov_d     = 1'b1;
                okind_d  = ktst_pkg::KIND_EXPIRED;
                ofound_d = 1'b0;
                okey_d   = pkey_q;
                otag_d   = ptag_q;
                olast_d  = 1'b0;
              end
              pend_d = 1'b1;
              pkey_d = c_key[0];
              ptag_d = c_tag[0];
            end
          end
        end
      endcase
      if (shift) cnt_d = cnt_q + 1'b1;
    end else if (busy_q) begin
      if (func_q == ktst_pkg::FUNC_TICK && !pend_q) begin
        busy_d = 1'b0;
      end else if (can_load) begin
        busy_d   = 1'b0;
        ov_d     = 1'b1;
        okey_d   = key_q;
        otag_d   = '0;
        olast_d  = 1'b1;
        ofound_d = 1'b0;
        unique case (func_q)
          ktst_pkg::FUNC_START:  okind_d = hit_q ? ktst_pkg::KIND_STARTED : ktst_pkg::KIND_FULL;
          ktst_pkg::FUNC_CANCEL: begin
            okind_d  = ktst_pkg::KIND_CANCEL;
            ofound_d = hit_q;
          end
          ktst_pkg::FUNC_QUERY: begin
            okind_d  = ktst_pkg::KIND_QUERY;
            ofound_d = hit_q;
          end
          default: begin
            okind_d = ktst_pkg::KIND_EXPIRED;
            okey_d  = pkey_q;
            otag_d  = ptag_q;
            pend_d  = 1'b0;
          end
        endcase
      end
    end
    if (accept) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      hit_d  = 1'b0;
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      hit_q  <= 1'b0;
      pend_q <= 1'b0;
      ov_q   <= 1'b0;
      now_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      hit_q  <= hit_d;
      pend_q <= pend_d;
      ov_q   <= ov_d;
      if (accept && in_i.func == ktst_pkg::FUNC_TICK) now_q <= now_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= in_i.func;
      key_q  <= in_key_w[KEY_BITS-1:0];
      dur_q  <= in_i.duration_ms;
      tag_q  <= in_i.tag;
    end
    pkey_q   <= pkey_d;
    ptag_q   <= ptag_d;
    okind_q  <= okind_d;
    ofound_q <= ofound_d;
    okey_q   <= okey_d;
    otag_q   <= otag_d;
    olast_q  <= olast_d;
  end

  assign out_key_w     = WK'(okey_q);
  assign in_i.ready    = !busy_q;
  assign out_o.valid   = ov_q;
  assign out_o.kind    = okind_q;
  assign out_o.found   = ofound_q;
  assign out_o.out_key = out_key_w[ktst_pkg::KEY_W-1:0];
  assign out_o.out_tag = otag_q;
  assign out_o.last    = olast_q;

endmodule

@@ src/ktst_checker.sv @@
// Port-level checks for the keyed timer slot table, bound to the top level.
module ktst_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind,
  input logic       out_found,
  input logic [31:0] out_tag,
  input logic       out_last
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_tag))
    else $error("result dropped while stalled");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_kind <= ktst_pkg::KIND_EXPIRED)
    else $error("result kind out of range");

  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_found |->
      (out_kind == ktst_pkg::KIND_CANCEL || out_kind == ktst_pkg::KIND_QUERY))
    else $error("found set on a result kind that has none");

  a_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind != ktst_pkg::KIND_EXPIRED |-> out_tag == '0 && out_last)
    else $error("reply carries a tag or is not last");

endmodule

bind keyed_timer_slot_table_unit ktst_checker u_ktst_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_kind  (out_o.kind),
  .out_found (out_o.found),
  .out_tag   (out_o.out_tag),
  .out_last  (out_o.last)
);

@@ verif/testbench.sv @@
// Self-checking testbench for the keyed timer slot table: predictor, stimulus and checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = ktst_pkg::SLOT_COUNT_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  kind;
    logic        found;
    logic [7:0]  key;
    logic [31:0] tag;
    logic        last;
  } timer_event_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ktst_in_if  req_ch ();
  ktst_out_if evt_ch ();

  keyed_timer_slot_table_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_ch.sink),
    .out_o (evt_ch.source)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Shadow copy of the timer table.
  logic [31:0] now_ms;
  logic        live[NSLOT];
  logic [7:0]  owner[NSLOT];
  logic [31:0] begun[NSLOT];
  logic [31:0] span[NSLOT];
  logic [31:0] label[NSLOT];

  timer_event_t pending_events[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  function automatic int slot_of(logic [7:0] k);
    for (int i = 0; i < NSLOT; i++) begin
      if (live[i] && owner[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic void push_event(logic [2:0] kd, logic fd, logic [7:0] k,
                                     logic [31:0] tg, logic lst);
    timer_event_t e;
    e.kind = kd; e.found = fd; e.key = k; e.tag = tg; e.last = lst;
    pending_events.push_back(e);
  endfunction

  function automatic void predict_timers(logic [1:0] fn, logic [7:0] k,
                                         logic [31:0] dur, logic [31:0] tg);
    int hit;
    int fired;
    hit = -1;
    fired = 0;
    case (fn)
      ktst_pkg::FUNC_START: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (hit < 0 && (!live[i] || owner[i] == k)) hit = i;
        end
        if (hit >= 0) begin
          live[hit] = 1'b1; owner[hit] = k; begun[hit] = now_ms;
          span[hit] = dur; label[hit] = tg;
          for (int j = hit + 1; j < NSLOT; j++) begin
            if (live[j] && owner[j] == k) live[j] = 1'b0;
          end
          push_event(ktst_pkg::KIND_STARTED, 1'b0, k, '0, 1'b1);
        end else begin
          push_event(ktst_pkg::KIND_FULL, 1'b0, k, '0, 1'b1);
        end
      end
      ktst_pkg::FUNC_CANCEL: begin
        hit = slot_of(k);
        if (hit >= 0) live[hit] = 1'b0;
        push_event(ktst_pkg::KIND_CANCEL, hit >= 0, k, '0, 1'b1);
      end
      ktst_pkg::FUNC_QUERY: begin
        hit = slot_of(k);
        push_event(ktst_pkg::KIND_QUERY, hit >= 0, k, '0, 1'b1);
      end
      default: begin
        now_ms = now_ms + 32'd1;
        for (int i = 0; i < NSLOT; i++) begin
          if (live[i] && (now_ms - begun[i]) >= span[i]) begin
            live[i] = 1'b0;
            push_event(ktst_pkg::KIND_EXPIRED, 1'b0, owner[i], label[i], 1'b0);
            fired++;
          end
        end
        if (fired > 0) pending_events[$].last = 1'b1;
      end
    endcase
  endfunction

  // Valid stays up after an acceptance; the DUT is busy then, and the next
  // call either drops it in an idle cycle or replaces the request.
  task automatic send_request(logic [1:0] fn, logic [7:0] k, logic [31:0] dur,
                              logic [31:0] tg);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.func <= fn;
    req_ch.key <= k;
    req_ch.duration_ms <= dur;
    req_ch.tag <= tg;
    do @(posedge clk_i); while (!req_ch.ready);
    predict_timers(fn, k, dur, tg);
  endtask

  task automatic drain_events();
    req_ch.valid <= 1'b0;
    while (pending_events.size() > 0) @(posedge clk_i);
    repeat (NSLOT + 8) @(posedge clk_i);
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk_i) begin
    timer_event_t want;
    if (rst_ni) begin
      if (evt_ch.valid && evt_ch.ready) begin
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected result kind=%0d key=%0h", $time, evt_ch.kind,
                   evt_ch.out_key);
          fail_count++;
        end else begin
          want = pending_events.pop_front();
          if (want.kind !== evt_ch.kind || want.found !== evt_ch.found ||
              want.key !== evt_ch.out_key || want.tag !== evt_ch.out_tag ||
              want.last !== evt_ch.last) begin
            $display("%0t: mismatch expected k=%0d f=%0d key=%0h tag=%0h l=%0d",
                     $time, want.kind, want.found, want.key, want.tag, want.last);
            $display("%0t:          actual   k=%0d f=%0d key=%0h tag=%0h l=%0d",
                     $time, evt_ch.kind, evt_ch.found, evt_ch.out_key,
                     evt_ch.out_tag, evt_ch.last);
            fail_count++;
          end
        end
      end
      evt_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if ((req_ch.valid && req_ch.ready) || (evt_ch.valid && evt_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic test_basic_ops();
    send_request(ktst_pkg::FUNC_QUERY, 8'h00, '0, '0);
    send_request(ktst_pkg::FUNC_CANCEL, 8'hFF, '0, '0);
    send_request(ktst_pkg::FUNC_START, 8'h00, 32'd0, 32'hFFFF_FFFF);
    send_request(ktst_pkg::FUNC_START, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(ktst_pkg::FUNC_START, 8'h5A, 32'd2, 32'hA5A5_5A5A);
    send_request(ktst_pkg::FUNC_QUERY, 8'hFF, '0, '0);
    send_request(ktst_pkg::FUNC_TICK, 8'h00, '0, '0);  // zero duration fires here
    send_request(ktst_pkg::FUNC_TICK, 8'h00, '0, '0);  // key 5A expires here
    send_request(ktst_pkg::FUNC_TICK, 8'h00, '0, '0);
    send_request(ktst_pkg::FUNC_CANCEL, 8'hFF, '0, '0);
    send_request(ktst_pkg::FUNC_QUERY, 8'hFF, '0, '0);
  endtask

  task automatic test_restart_and_full();
    // Fill every slot, then free a low one so a restart lands below the key.
    for (int i = 0; i < NSLOT; i++) begin
      send_request(ktst_pkg::FUNC_START, 8'(i), 32'd50, 32'(i));
    end
    send_request(ktst_pkg::FUNC_START, 8'hEE, 32'd5, 32'h1);      // table full
    send_request(ktst_pkg::FUNC_CANCEL, 8'd1, '0, '0);
    send_request(ktst_pkg::FUNC_START, 8'd7, 32'd3, 32'hCAFE);    // lower free slot wins
    send_request(ktst_pkg::FUNC_START, 8'd7, 32'd4, 32'hBEEF);    // reuse the key's slot
    repeat (60) send_request(ktst_pkg::FUNC_TICK, 8'h00, '0, '0); // many expire at once
    drain_events();
  endtask

  task automatic test_random_mix(int count);
    logic [1:0] fn;
    for (int n = 0; n < count; n++) begin
      fn = 2'($urandom_range(3));
      send_request(fn, 8'($urandom_range(15)) ^ ($urandom_range(9) == 0 ? 8'($urandom) : 8'h0),
                   $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(12)), $urandom);
      if (n == count / 2) begin
        req_ch.valid <= 1'b0;
        do @(posedge clk_i); while (pending_events.size() > 0);
      end
    end
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.func = ktst_pkg::FUNC_QUERY;
    req_ch.key = '0;
    req_ch.duration_ms = '0;
    req_ch.tag = '0;
    evt_ch.ready = 1'b0;
    now_ms = '0;
    for (int i = 0; i < NSLOT; i++) live[i] = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 33; recv_idle_pct = 70;
    test_basic_ops();
    test_restart_and_full();
    test_random_mix(77);
    send_idle_pct = 70; recv_idle_pct = 33;
    test_random_mix(77);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random_mix(77);
    drain_events();
    if (fail_count == 0 && pending_events.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
src/ktst_pkg.sv
src/ktst_if.sv
src/ktst_cell.sv
src/keyed_timer_slot_table_unit.sv
src/ktst_checker.sv
verif/testbench.sv
